FILE: hdl/ffnea_pkg.sv
// Shared constants, codes and controller/datapath interface types for the ring arbiter.
`default_nettype none

package ffnea_pkg;

	// Fixed field widths of the item and result beats.
	localparam int SEAT_W   = 3;
	localparam int STATUS_W = 3;
	localparam int CNT_W    = 4;

	// Seat count register reset value.
	localparam logic [CNT_W-1:0] CNT_RESET = 4'd8;

	// Configuration port geometry.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_SEAT_COUNT = '0;

	// Opcodes of an item beat.
	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_GRANTED  = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_QUEUED   = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_RELEASED = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_WOKEN    = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_REJECTED = 3'd4;

	// At most this many wake-up grants follow one release.
	localparam int WAKE_LIMIT = 4;
	localparam int WAKE_W     = $clog2(WAKE_LIMIT);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;    // latch the item beat
		logic exec;       // apply the request or release
		logic head_load;  // read the queue head entry
		logic reduce;     // one modulo step on the head seat index
		logic wake;       // grant the queue head, push pending result as non-final
		logic flush;      // push pending result as final
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic release_wakes;  // accepted release with a non-empty queue
		logic rem_ge_n;       // head seat index still needs reduction
		logic head_free;      // both neighbors of the head seat are free
		logic fill_gt1;       // more than one seat queued
		logic out_free;       // output register can take a beat
	} stat_t;

endpackage

`default_nettype wire

FILE: hdl/fifo_fair_neighbor_exclusion_arbiter_unit.sv
// Top level of the FIFO-fair neighbor-exclusion ring arbiter.
//
// Channel   Direction  Handshake                     Payload
// item      in         item_valid / item_stall       opcode, seat
// result    out        result_valid / result_stall   target_seat, status, last
// config    in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// An item that does not examine the queue goes from acceptance through the execute and
// flush states to its final result beat. After an accepted release with seats queued, each
// queue head checked adds a queue read and a neighbor check, whether it is woken or found
// blocked, plus the modulo steps when a queued seat lies beyond a shrunken ring; at most
// four are woken. One item is worked on at a time; the controller stalls new items until idle.
// Reset clears all seat flags and the queue; the seat count returns to eight.
// A stalled result beat holds the output register, and the controller waits for it.
`default_nettype none

module fifo_fair_neighbor_exclusion_arbiter_unit #(
	parameter int MAX_SEATS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic                                 opcode,
	input  logic [ffnea_pkg::SEAT_W-1:0]         seat,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [ffnea_pkg::SEAT_W-1:0]         target_seat,
	output logic [ffnea_pkg::STATUS_W-1:0]       status,
	output logic                                 last,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ffnea_pkg::PADDR_W-1:0]        paddr,
	input  logic [ffnea_pkg::PDATA_W-1:0]        pwdata,
	output logic [ffnea_pkg::PDATA_W-1:0]        prdata,
	output logic                                 pready
);

	ffnea_pkg::cmd_t                   cmd;
	ffnea_pkg::stat_t                  stat;
	logic                              cfg_we;
	logic                              reg_hit;
	logic [ffnea_pkg::CNT_W-1:0]       seat_count;

	// Register decode on the word address.
	assign reg_hit = (paddr[ffnea_pkg::PADDR_W-1:2] == ffnea_pkg::REG_SEAT_COUNT);
	assign cfg_we  = psel && penable && pwrite && reg_hit;
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? ffnea_pkg::PDATA_W'(seat_count) : '0;

	ffnea_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	ffnea_dpath #(
		.MAX_SEATS (MAX_SEATS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_data     (pwdata[ffnea_pkg::CNT_W-1:0]),
		.seat_count   (seat_count),
		.opcode       (opcode),
		.seat         (seat),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.target_seat  (target_seat),
		.status       (status),
		.last         (last)
	);

endmodule

`default_nettype wire

FILE: hdl/ffnea_ctrl.sv
// Controller state machine for the ring arbiter: sequences capture, execution and wake-ups.
`default_nettype none

module ffnea_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  ffnea_pkg::stat_t  stat,
	output ffnea_pkg::cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_HEAD,
		S_REDUCE,
		S_FLUSH
	} state_t;

	state_t                        state_q, state_d;
	logic [ffnea_pkg::WAKE_W-1:0]  wake_cnt_q, wake_cnt_d;

	// Only an idle controller takes a new item.
	assign item_stall = (state_q != S_IDLE);

	// Next state and command decode.
	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		wake_cnt_d = wake_cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec   = 1'b1;
				wake_cnt_d = '0;
				state_d    = stat.release_wakes ? S_HEAD : S_FLUSH;
			end
			S_HEAD: begin
				cmd.head_load = 1'b1;
				state_d       = S_REDUCE;
			end
			S_REDUCE: begin
				if (stat.rem_ge_n) begin
					cmd.reduce = 1'b1;
				end else if (!stat.head_free) begin
					state_d = S_FLUSH;
				end else if (stat.out_free) begin
					cmd.wake   = 1'b1;
					wake_cnt_d = wake_cnt_q + ffnea_pkg::WAKE_W'(1);
					if (stat.fill_gt1 &&
					    wake_cnt_q != ffnea_pkg::WAKE_W'(ffnea_pkg::WAKE_LIMIT - 1)) begin
						state_d = S_HEAD;
					end else begin
						state_d = S_FLUSH;
					end
				end
			end
			S_FLUSH: begin
				if (stat.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and wake-up counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			wake_cnt_q <= '0;
		end else begin
			state_q    <= state_d;
			wake_cnt_q <= wake_cnt_d;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/ffnea_dpath.sv
// Datapath for the ring arbiter: seat state, wait queue, neighbor checks and result register.
`default_nettype none

module ffnea_dpath #(
	parameter int MAX_SEATS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ffnea_pkg::cmd_t                     cmd,
	output ffnea_pkg::stat_t                    stat,
	input  logic                                cfg_we,
	input  logic [ffnea_pkg::CNT_W-1:0]         cfg_data,
	output logic [ffnea_pkg::CNT_W-1:0]         seat_count,
	input  logic                                opcode,
	input  logic [ffnea_pkg::SEAT_W-1:0]        seat,
	input  logic                                result_stall,
	output logic                                result_valid,
	output logic [ffnea_pkg::SEAT_W-1:0]        target_seat,
	output logic [ffnea_pkg::STATUS_W-1:0]      status,
	output logic                                last
);

	localparam int SW = $clog2(MAX_SEATS);
	localparam int NW = $clog2(MAX_SEATS + 1);

	// Seat state: one granted and one queued flag per seat.
	logic [MAX_SEATS-1:0]               granted_q;
	logic [MAX_SEATS-1:0]               queued_q;

	// Circular wait queue.
	logic [SW-1:0]                      ring_q [MAX_SEATS];
	logic [SW-1:0]                      head_q;
	logic [NW-1:0]                      fill_q;

	logic [ffnea_pkg::CNT_W-1:0]        count_q;

	// Captured item and working registers.
	logic                               op_q;
	logic [ffnea_pkg::SEAT_W-1:0]       seat_q;
	logic [SW-1:0]                      hseat_q;
	logic [NW-1:0]                      rem_q;

	// Result held back until it is known whether it is the final one.
	logic [ffnea_pkg::SEAT_W-1:0]       pend_seat_q;
	logic [ffnea_pkg::STATUS_W-1:0]     pend_status_q;

	// Output register.
	logic                               out_valid_q;
	logic [ffnea_pkg::SEAT_W-1:0]       out_seat_q;
	logic [ffnea_pkg::STATUS_W-1:0]     out_status_q;
	logic                               out_last_q;

	logic [NW-1:0]                      ring_n;
	logic [SW-1:0]                      s_ix;
	logic                               s_in_ring;
	logic                               s_in_range;
	logic                               req_free;
	logic                               wake_free;
	logic                               ex_grant;
	logic                               ex_enq;
	logic                               ex_rel;
	logic [ffnea_pkg::STATUS_W-1:0]     ex_status;
	logic [SW:0]                        tail_sum;
	logic [SW-1:0]                      tail;
	logic [SW-1:0]                      head_next;

	// True when neither ring neighbor of seat r (r below the ring size) holds a grant.
	function automatic logic nb_free(input logic [NW-1:0] r, input logic [NW-1:0] sz,
	                                 input logic [MAX_SEATS-1:0] g);
		logic [NW-1:0] rt;
		logic [NW-1:0] lf;
		rt = (r + NW'(1) == sz) ? '0 : r + NW'(1);
		lf = (r == '0) ? sz - NW'(1) : r - NW'(1);
		return !g[SW'(rt)] && !g[SW'(lf)];
	endfunction

	// Ring size in use: the register saturated into the supported range.
	always_comb begin
		if (32'(count_q) < 32'd2) begin
			ring_n = NW'(2);
		end else if (32'(count_q) > 32'(MAX_SEATS)) begin
			ring_n = NW'(MAX_SEATS);
		end else begin
			ring_n = NW'(count_q);
		end
	end

	assign s_ix       = SW'(seat_q);
	assign s_in_ring  = 32'(seat_q) < 32'(ring_n);
	assign s_in_range = 32'(seat_q) < 32'(MAX_SEATS);
	assign req_free   = nb_free(NW'(seat_q), ring_n, granted_q);
	assign wake_free  = nb_free(rem_q, ring_n, granted_q);

	// Decision for the captured request or release.
	always_comb begin
		ex_grant  = 1'b0;
		ex_enq    = 1'b0;
		ex_rel    = 1'b0;
		ex_status = ffnea_pkg::STATUS_REJECTED;
		if (op_q == ffnea_pkg::OP_REQUEST) begin
			if (!s_in_ring || granted_q[s_ix] || queued_q[s_ix]) begin
				ex_status = ffnea_pkg::STATUS_REJECTED;
			end else if (fill_q == '0 && req_free) begin
				ex_grant  = 1'b1;
				ex_status = ffnea_pkg::STATUS_GRANTED;
			end else if (fill_q >= NW'(MAX_SEATS)) begin
				ex_status = ffnea_pkg::STATUS_REJECTED;
			end else begin
				ex_enq    = 1'b1;
				ex_status = ffnea_pkg::STATUS_QUEUED;
			end
		end else if (s_in_range && granted_q[s_ix]) begin
			ex_rel    = 1'b1;
			ex_status = ffnea_pkg::STATUS_RELEASED;
		end
	end

	// Queue tail and head advance, both wrapping at the queue depth.
	assign tail_sum  = (SW+1)'(head_q) + (SW+1)'(fill_q);
	assign tail      = SW'((tail_sum >= (SW+1)'(MAX_SEATS)) ?
	                       tail_sum - (SW+1)'(MAX_SEATS) : tail_sum);
	assign head_next = (head_q == SW'(MAX_SEATS - 1)) ? '0 : head_q + SW'(1);

	// Status toward the controller.
	always_comb begin
		stat               = '0;
		stat.release_wakes = ex_rel && (fill_q != '0);
		stat.rem_ge_n      = (rem_q >= ring_n);
		stat.head_free     = wake_free;
		stat.fill_gt1      = (fill_q > NW'(1));
		stat.out_free      = !out_valid_q || !result_stall;
	end

	// Control state: register, seat flags, queue pointers and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= ffnea_pkg::CNT_RESET;
			granted_q   <= '0;
			queued_q    <= '0;
			head_q      <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_data;
			end
			if (cmd.exec) begin
				if (ex_grant) begin
					granted_q[s_ix] <= 1'b1;
				end
				if (ex_enq) begin
					queued_q[s_ix] <= 1'b1;
					fill_q         <= fill_q + NW'(1);
				end
				if (ex_rel) begin
					granted_q[s_ix] <= 1'b0;
				end
			end
			if (cmd.wake) begin
				granted_q[hseat_q] <= 1'b1;
				queued_q[hseat_q]  <= 1'b0;
				head_q             <= head_next;
				fill_q             <= fill_q - NW'(1);
			end
			if (cmd.wake || cmd.flush) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: item capture, queue storage, head reduction and result beats.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= opcode;
			seat_q <= seat;
		end
		if (cmd.exec) begin
			pend_seat_q   <= seat_q;
			pend_status_q <= ex_status;
			if (ex_enq) begin
				ring_q[tail] <= SW'(seat_q);
			end
		end
		if (cmd.head_load) begin
			hseat_q <= ring_q[head_q];
			rem_q   <= NW'(ring_q[head_q]);
		end else if (cmd.reduce) begin
			rem_q <= rem_q - ring_n;
		end
		if (cmd.wake || cmd.flush) begin
			out_seat_q   <= pend_seat_q;
			out_status_q <= pend_status_q;
			out_last_q   <= cmd.flush;
		end
		if (cmd.wake) begin
			pend_seat_q   <= ffnea_pkg::SEAT_W'(hseat_q);
			pend_status_q <= ffnea_pkg::STATUS_WOKEN;
		end
	end

	assign seat_count   = count_q;
	assign result_valid = out_valid_q;
	assign target_seat  = out_seat_q;
	assign status       = out_status_q;
	assign last         = out_last_q;

endmodule

`default_nettype wire
